### sv/rv32ie_pkg.sv
// Package for the RV32I integer execute unit.
// Holds opcodes, funct3/funct7 codes, the status code and the execute result type.
// No dependencies.
package rv32ie_pkg;

    localparam int XLEN       = 32;
    localparam int REG_COUNT  = 32;
    localparam int REG_IDX_W  = 5;

    // Major opcodes
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_FENCE  = 7'h0F;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    // ALU funct3
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    // Load / store / branch funct3
    localparam logic [2:0] F3_LB   = 3'd0;
    localparam logic [2:0] F3_LH   = 3'd1;
    localparam logic [2:0] F3_LW   = 3'd2;
    localparam logic [2:0] F3_LBU  = 3'd4;
    localparam logic [2:0] F3_LHU  = 3'd5;
    localparam logic [2:0] F3_SB   = 3'd0;
    localparam logic [2:0] F3_SH   = 3'd1;
    localparam logic [2:0] F3_SW   = 3'd2;
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;
    // JALR, FENCE and PRIV all use funct3 zero
    localparam logic [2:0] F3_BASE = 3'd0;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    localparam logic [XLEN-1:0] UPPER_MASK = 32'hFFFF_F000;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_NOTIMPL = 2'd2
    } status_t;

    // Packed so that write_enable sits in bit 0, as on the result channel
    typedef struct packed {
        status_t              status;
        logic [XLEN-1:0]      write_value;
        logic [REG_IDX_W-1:0] write_register;
        logic                 write_enable;
    } exec_result_t;

endpackage

### sv/rv32i_integer_execute_unit.sv
// RV32I integer execute unit: top level with operand stage, register file and
// result register. Depends on rv32ie_pkg and rv32ie_alu.
//
// The unit takes one instruction request per clock (instruction and program
// counter on s_tdata) and returns exactly one result request per instruction on
// m_tdata, in order. OP, OP-IMM, LUI and AUIPC are executed against a 32 x 32-bit
// register file that reads as all zero after reset; x0 is never written. Loads,
// stores, branches, jumps, FENCE and SYSTEM report "not implemented" and other
// encodings report "unknown"; neither writes. Throughput is one instruction per
// clock while m_tready is held high; an accepted request is held in the operand
// registers and then in the result register, which drives m_tvalid. The rate is
// set by the single-pass execute path between the operand registers and the
// result register: operands are read from the register file when the request is
// accepted, and a write made by the instruction leaving execute on that same
// edge is forwarded into the operand registers. The result register lets a new
// request enter while a finished one still waits for m_tready.
module rv32i_integer_execute_unit
    import rv32ie_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: [31:0] instruction, [63:32] program_counter
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,
    // m_tdata: [0] write_enable, [5:1] write_register, [37:6] write_value,
    //          [39:38] status
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata
);

    // Execute stage registers
    logic                 ex_valid_reg;
    logic [XLEN-1:0]      ex_instr_reg;
    logic [XLEN-1:0]      ex_pc_reg;
    logic [XLEN-1:0]      rs1_val_reg;
    logic [XLEN-1:0]      rs2_val_reg;
    logic [XLEN-1:0]      rs1_val_next;
    logic [XLEN-1:0]      rs2_val_next;

    // Register file: storage plus a written flag per entry; unwritten reads zero
    logic [XLEN-1:0]      rf_mem [REG_COUNT];
    logic [REG_COUNT-1:0] rf_valid_reg;

    // Result register
    logic                 m_tvalid_reg;
    exec_result_t         m_result_reg;

    exec_result_t         ex_result;
    logic                 out_free;
    logic                 advance;
    logic                 accept;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] s_rs1;
    logic [REG_IDX_W-1:0] s_rs2;

    rv32ie_alu u_alu (
        .instruction     (ex_instr_reg),
        .program_counter (ex_pc_reg),
        .rs1_value       (rs1_val_reg),
        .rs2_value       (rs2_val_reg),
        .result          (ex_result)
    );

    // Result slot frees when empty or being taken this cycle
    assign out_free = !m_tvalid_reg || m_tready;
    // Move the execute-stage instruction into the result register
    assign advance  = ex_valid_reg && out_free;
    // Take a new request when execute is empty or draining this cycle
    assign s_tready = !ex_valid_reg || out_free;
    assign accept   = s_tvalid && s_tready;
    // Commit the register write together with the result
    assign wr_en    = advance && ex_result.write_enable;

    assign s_rs1 = s_tdata[19:15];
    assign s_rs2 = s_tdata[24:20];

    // Read the register file for the incoming request; forward a write landing
    // on the same edge so back-to-back dependent instructions see it
    always_comb begin
        if (wr_en && ex_result.write_register == s_rs1)
            rs1_val_next = ex_result.write_value;
        else if (rf_valid_reg[s_rs1])
            rs1_val_next = rf_mem[s_rs1];
        else
            rs1_val_next = '0;

        if (wr_en && ex_result.write_register == s_rs2)
            rs2_val_next = ex_result.write_value;
        else if (rf_valid_reg[s_rs2])
            rs2_val_next = rf_mem[s_rs2];
        else
            rs2_val_next = '0;
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ex_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            rf_valid_reg <= '0;
        end else begin
            if (accept)
                ex_valid_reg <= 1'b1;
            else if (advance)
                ex_valid_reg <= 1'b0;

            if (advance)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;

            if (wr_en)
                rf_valid_reg[ex_result.write_register] <= 1'b1;
        end
    end

    // Operand registers: load on accept, hold otherwise
    always_ff @(posedge aclk) begin
        if (accept) begin
            ex_instr_reg <= s_tdata[31:0];
            ex_pc_reg    <= s_tdata[63:32];
            rs1_val_reg  <= rs1_val_next;
            rs2_val_reg  <= rs2_val_next;
        end
    end

    // Register file write port
    always_ff @(posedge aclk) begin
        if (wr_en)
            rf_mem[ex_result.write_register] <= ex_result.write_value;
    end

    // Result register: load on advance, hold while stalled
    always_ff @(posedge aclk) begin
        if (advance)
            m_result_reg <= ex_result;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_result_reg;

    // A result that is not executed carries no write
    a_no_write_unless_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_result_reg.status != ST_DONE) |-> !m_result_reg.write_enable)
        else $error("write reported for a non-executed instruction");

    // x0 is never written
    a_no_x0_write: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (ex_result.write_register != '0))
        else $error("write to x0");

    // An idle write slot carries zero index and value
    a_quiet_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_result_reg.write_enable) |->
            (m_result_reg.write_register == '0 && m_result_reg.write_value == '0))
        else $error("nonzero write fields without write enable");

    // An accepted request occupies the execute stage on the next cycle
    a_accept_fills_ex: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> ex_valid_reg)
        else $error("accepted request lost");

    // A stalled result blocks the execute stage from draining
    a_stall_holds_ex: assert property (@(posedge aclk) disable iff (!aresetn)
        (ex_valid_reg && m_tvalid_reg && !m_tready) |=> ex_valid_reg)
        else $error("execute stage drained into a full result register");

endmodule

### sv/rv32ie_alu.sv
// Decode and integer ALU for one RV32I instruction, purely combinational.
// Depends on rv32ie_pkg.
module rv32ie_alu
    import rv32ie_pkg::*;
(
    input  logic [XLEN-1:0] instruction,
    input  logic [XLEN-1:0] program_counter,
    input  logic [XLEN-1:0] rs1_value,
    input  logic [XLEN-1:0] rs2_value,
    output exec_result_t    result
);

    logic [6:0]           opcode;
    logic [REG_IDX_W-1:0] rd;
    logic [2:0]           funct3;
    logic [REG_IDX_W-1:0] rs2_idx;
    logic [6:0]           funct7;
    logic [XLEN-1:0]      imm_i;
    logic [XLEN-1:0]      operand_b;
    logic                 alt;
    logic [XLEN-1:0]      alu_out;
    logic [XLEN-1:0]      value;
    status_t              status;
    logic [4:0]           shamt;

    assign opcode  = instruction[6:0];
    assign rd      = instruction[11:7];
    assign funct3  = instruction[14:12];
    assign rs2_idx = instruction[24:20];
    assign funct7  = instruction[31:25];
    assign imm_i   = {{20{instruction[31]}}, instruction[31:20]};
    assign shamt   = operand_b[4:0];

    // Pick operand B and the SUB/SRA select
    always_comb begin
        if (opcode == OPC_OP) begin
            operand_b = rs2_value;
            alt       = (funct7 == F7_ALT);
        end else if (funct3 == F3_SLL || funct3 == F3_SR) begin
            operand_b = {{(XLEN-REG_IDX_W){1'b0}}, rs2_idx};
            alt       = (funct3 == F3_SR) && (funct7 == F7_ALT);
        end else begin
            operand_b = imm_i;
            alt       = 1'b0;
        end
    end

    always_comb begin
        case (funct3)
            F3_ADD:  alu_out = alt ? (rs1_value - operand_b) : (rs1_value + operand_b);
            F3_SLL:  alu_out = rs1_value << shamt;
            F3_SLT:  alu_out = {{(XLEN-1){1'b0}}, ($signed(rs1_value) < $signed(operand_b))};
            F3_SLTU: alu_out = {{(XLEN-1){1'b0}}, (rs1_value < operand_b)};
            F3_XOR:  alu_out = rs1_value ^ operand_b;
            F3_SR:   alu_out = alt ? XLEN'($signed(rs1_value) >>> shamt)
                                   : (rs1_value >> shamt);
            F3_OR:   alu_out = rs1_value | operand_b;
            F3_AND:  alu_out = rs1_value & operand_b;
            default: alu_out = '0;
        endcase
    end

    always_comb begin
        status = ST_UNKNOWN;
        value  = alu_out;
        case (opcode)
            OPC_OP: begin
                if (funct7 == F7_BASE ||
                    (funct7 == F7_ALT && (funct3 == F3_ADD || funct3 == F3_SR)))
                    status = ST_DONE;
            end
            OPC_OPIMM: begin
                if (funct3 == F3_SLL) begin
                    if (funct7 == F7_BASE) status = ST_DONE;
                end else if (funct3 == F3_SR) begin
                    if (funct7 == F7_BASE || funct7 == F7_ALT) status = ST_DONE;
                end else begin
                    status = ST_DONE;
                end
            end
            OPC_LUI: begin
                value  = instruction & UPPER_MASK;
                status = ST_DONE;
            end
            OPC_AUIPC: begin
                value  = program_counter + (instruction & UPPER_MASK);
                status = ST_DONE;
            end
            OPC_LOAD: begin
                if (funct3 == F3_LB || funct3 == F3_LH || funct3 == F3_LW ||
                    funct3 == F3_LBU || funct3 == F3_LHU)
                    status = ST_NOTIMPL;
            end
            OPC_STORE: begin
                if (funct3 == F3_SB || funct3 == F3_SH || funct3 == F3_SW)
                    status = ST_NOTIMPL;
            end
            OPC_BRANCH: begin
                if (funct3 == F3_BEQ || funct3 == F3_BNE || funct3 == F3_BLT ||
                    funct3 == F3_BGE || funct3 == F3_BLTU || funct3 == F3_BGEU)
                    status = ST_NOTIMPL;
            end
            OPC_JAL: begin
                status = ST_NOTIMPL;
            end
            OPC_JALR, OPC_FENCE, OPC_SYSTEM: begin
                if (funct3 == F3_BASE) status = ST_NOTIMPL;
            end
            default: begin
                status = ST_UNKNOWN;
            end
        endcase
    end

    // Report a write only for an executed instruction with a nonzero destination
    always_comb begin
        result.status = status;
        if (status == ST_DONE && rd != '0) begin
            result.write_enable   = 1'b1;
            result.write_register = rd;
            result.write_value    = value;
        end else begin
            result.write_enable   = 1'b0;
            result.write_register = '0;
            result.write_value    = '0;
        end
    end

endmodule
